// ----- rtl/fnac_pkg.sv -----
package fnac_pkg;

  // Default sizing, handed to the top level parameters
  localparam int DEF_MAX_WIN     = 1024;
  localparam int DEF_MAX_LAGS    = 64;
  localparam int DEF_RING_DEPTH  = 2048;
  localparam int DEF_SAMPLE_BITS = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int WIN_CFG_W  = 11;
  localparam int HOP_CFG_W  = 11;
  localparam int LAGS_CFG_W = 7;

  localparam logic [WIN_CFG_W-1:0]  WIN_RST  = 11'd400;
  localparam logic [HOP_CFG_W-1:0]  HOP_RST  = 11'd160;
  localparam logic [LAGS_CFG_W-1:0] LAGS_RST = 7'd64;
  localparam logic                  NORM_RST = 1'b1;

  // Result fields and index counters
  localparam int LAG_W  = 6;
  localparam int RAW_W  = 48;
  localparam int NORM_W = 16;
  localparam int IDX_W  = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_LEN   = 2'd0,
    REG_HOP_LEN   = 2'd1,
    REG_LAG_COUNT = 2'd2,
    REG_NORMALIZE = 2'd3
  } cfg_reg_e;

  // Control broadcast to every correlation cell
  typedef struct packed {
    logic clear;  // start of frame: zero sums, clear tap valids
    logic beat;   // a ring sample enters the chain
    logic drain;  // shift sums one cell toward the head
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_STREAM,
    C_FLUSH,
    C_NSTART,
    C_NWAIT,
    C_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_MUL,
    N_INIT,
    N_ROOT,
    N_DONE
  } norm_state_e;

endpackage

// ----- rtl/fnac_if.sv -----
// Sample channel
interface fnac_in_if #(
  parameter int SampleBits = fnac_pkg::DEF_SAMPLE_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         new_signal;

  modport source (output valid, sample, new_signal, input ready);
  modport sink (input valid, sample, new_signal, output ready);
endinterface

// Result channel, one beat per lag
interface fnac_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [fnac_pkg::LAG_W-1:0]           lag;
  logic signed [fnac_pkg::RAW_W-1:0]    raw_sum;
  logic signed [fnac_pkg::NORM_W-1:0]   norm_corr;
  logic                                 last_of_frame;

  modport source (output valid, lag, raw_sum, norm_corr, last_of_frame, input ready);
  modport sink (input valid, lag, raw_sum, norm_corr, last_of_frame, output ready);
endinterface

// ----- rtl/fnac_cell.sv -----
module fnac_cell #(
  parameter int SampleBits = fnac_pkg::DEF_SAMPLE_BITS,
  parameter int AccW       = 2 * fnac_pkg::DEF_SAMPLE_BITS + 11,
  parameter int EnW        = 2 * fnac_pkg::DEF_SAMPLE_BITS + 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fnac_pkg::cell_ctrl_t         ctrl_i,
  input  logic signed [SampleBits-1:0] y_i,
  input  logic signed [SampleBits-1:0] x_i,
  input  logic                         act_i,
  output logic signed [SampleBits-1:0] x_o,
  output logic                         act_o,
  input  logic signed [AccW-1:0]       raw_i,
  input  logic [EnW-1:0]               en_i,
  output logic signed [AccW-1:0]       raw_o,
  output logic [EnW-1:0]               en_o
);
  import fnac_pkg::*;

  localparam int PW = 2 * SampleBits;

  logic signed [SampleBits-1:0] x_q;
  logic                         act_q;
  logic                         pv_q;
  logic signed [PW-1:0]         pr_q;
  logic signed [PW-1:0]         pe_q;
  logic signed [AccW-1:0]       acc_r_q;
  logic [EnW-1:0]               acc_e_q;

  // Tap valid and product valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      pv_q  <= 1'b0;
    end else if (ctrl_i.clear) begin
      act_q <= 1'b0;
      pv_q  <= 1'b0;
    end else begin
      pv_q <= ctrl_i.beat & act_i;
      if (ctrl_i.beat) begin
        act_q <= act_i;
      end
    end
  end

  // Tap, products, and the two running sums
  always_ff @(posedge clk_i) begin
    if (ctrl_i.beat) begin
      x_q  <= x_i;
      pr_q <= x_i * y_i;
      pe_q <= y_i * y_i;
    end
    if (ctrl_i.clear) begin
      acc_r_q <= '0;
      acc_e_q <= '0;
    end else if (ctrl_i.drain) begin
      acc_r_q <= raw_i;
      acc_e_q <= en_i;
    end else if (pv_q) begin
      acc_r_q <= acc_r_q + AccW'(pr_q);
      acc_e_q <= acc_e_q + EnW'($unsigned(pe_q));
    end
  end

  assign x_o   = x_q;
  assign act_o = act_q;
  assign raw_o = acc_r_q;
  assign en_o  = acc_e_q;

endmodule

// ----- rtl/fnac_norm.sv -----
module fnac_norm #(
  parameter int AccW = 2 * fnac_pkg::DEF_SAMPLE_BITS + 11,
  parameter int EnW  = 2 * fnac_pkg::DEF_SAMPLE_BITS + 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              en_i,
  input  logic signed [AccW-1:0]            raw_i,
  input  logic [EnW-1:0]                    e0_i,
  input  logic [EnW-1:0]                    el_i,
  output logic                              done_o,
  output logic signed [fnac_pkg::NORM_W-1:0] q_o
);
  import fnac_pkg::*;

  localparam int ENX = (EnW > 33) ? EnW : 33;
  localparam int MW  = (AccW > 33) ? AccW : 33;
  localparam int W   = 97;

  norm_state_e      state_q, state_d;
  logic [ENX-1:0]   a_q, b_q;
  logic [MW-1:0]    m_q;
  logic             neg_q;
  logic [63:0]      p_q, mm_q;
  logic [W-1:0]     t_q, us_q, ps_q, r_q;
  logic [15:0]      k_q;
  logic [3:0]       bit_q;

  logic             a_big, b_big, skip, take;
  logic [1:0]       sh;
  logic [AccW-1:0]  abs_raw;
  logic [31:0]      msat;
  logic [W-1:0]     cand;
  logic [15:0]      kmag;

  assign a_big   = |a_q[ENX-1:32];
  assign b_big   = |b_q[ENX-1:32];
  assign sh      = {1'b0, a_big} + {1'b0, b_big};
  assign skip    = !en_i || (raw_i == '0) || (e0_i == '0) || (el_i == '0);
  assign abs_raw = raw_i[AccW-1] ? AccW'(-raw_i) : AccW'(raw_i);
  assign msat    = (|m_q[MW-1:32]) ? 32'hFFFF_FFFF : m_q[31:0];
  assign cand    = t_q + us_q + ps_q;
  assign take    = (cand <= r_q);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          state_d = skip ? N_DONE : N_SHIFT;
        end
      end
      N_SHIFT: begin
        if (!a_big && !b_big) begin
          state_d = N_MUL;
        end
      end
      N_MUL:  state_d = N_INIT;
      N_INIT: state_d = N_ROOT;
      N_ROOT: begin
        if (bit_q == 4'd0) begin
          state_d = N_DONE;
        end
      end
      N_DONE: state_d = N_IDLE;
      default: state_d = N_IDLE;
    endcase
  end

  // Datapath: even-shift normalize, products, then digit-by-digit root search
  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          a_q   <= ENX'(e0_i);
          b_q   <= ENX'(el_i);
          m_q   <= MW'(abs_raw);
          neg_q <= raw_i[AccW-1];
          k_q   <= '0;
        end
      end
      N_SHIFT: begin
        if (a_big) begin
          a_q <= a_q >> 2;
        end
        if (b_big) begin
          b_q <= b_q >> 2;
        end
        m_q <= m_q >> sh;
      end
      N_MUL: begin
        p_q  <= a_q[31:0] * b_q[31:0];
        mm_q <= msat * msat;
      end
      N_INIT: begin
        r_q   <= W'({mm_q, 30'b0});
        ps_q  <= W'({p_q, 30'b0});
        t_q   <= '0;
        us_q  <= '0;
        k_q   <= '0;
        bit_q <= 4'd15;
      end
      N_ROOT: begin
        // k^2*p tracked as t; us = k*p shifted to the current digit
        if (take) begin
          t_q  <= cand;
          us_q <= (us_q >> 1) + ps_q;
        end else begin
          us_q <= us_q >> 1;
        end
        ps_q       <= ps_q >> 2;
        k_q[bit_q] <= take;
        bit_q      <= bit_q - 4'd1;
      end
      default: ;
    endcase
  end

  // Clamp to 32768, apply sign, saturate positive side
  assign kmag   = (k_q >= 16'h8000) ? 16'h8000 : k_q;
  assign q_o    = neg_q ? -kmag : (kmag[15] ? 16'sh7FFF : kmag);
  assign done_o = (state_q == N_DONE);

endmodule

// ----- rtl/framed_normalized_autocorrelation.sv -----
// Per frame: win+lags-1 ring reads stream through the cell chain, then a flush; then each lag
// passes the normalizer (even right shifts of the energies, products, a 16-step root search),
// which is skipped (lag zero, normalize off, zero energy or zero sum), then its result beat.
// Throughput: one sample per cycle between frames; a frame holds the input until its last
// lag beat is taken. The sample ring has one write and one read port.
// Reset (async, active low) clears control, indices and config to defaults; the ring
// contents are undefined until written. RING_DEPTH must be a power of two.
module framed_normalized_autocorrelation #(
  parameter int MAX_WIN     = fnac_pkg::DEF_MAX_WIN,
  parameter int MAX_LAGS    = fnac_pkg::DEF_MAX_LAGS,
  parameter int RING_DEPTH  = fnac_pkg::DEF_RING_DEPTH,
  parameter int SAMPLE_BITS = fnac_pkg::DEF_SAMPLE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fnac_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fnac_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  fnac_in_if.sink                          in_i,
  fnac_out_if.source                       out_o
);
  import fnac_pkg::*;

  localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(MAX_WIN) + 1;
  localparam int EN_W  = 2 * SAMPLE_BITS + $clog2(MAX_WIN);
  localparam int RA_W  = $clog2(RING_DEPTH);
  localparam int KW    = $clog2(MAX_WIN + MAX_LAGS);
  localparam int WX    = (ACC_W > RAW_W) ? ACC_W : RAW_W;

  localparam logic signed [WX-1:0] RAW_HI = WX'({1'b0, {(RAW_W-1){1'b1}}});
  localparam logic signed [WX-1:0] RAW_LO = ~RAW_HI;

  // Config registers
  logic [WIN_CFG_W-1:0]  win_cfg_q;
  logic [HOP_CFG_W-1:0]  hop_cfg_q;
  logic [LAGS_CFG_W-1:0] lags_cfg_q;
  logic                  norm_en_q;

  ctrl_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, nfs_q, s_q;
  logic [KW-1:0]    rd_k_q;
  logic [1:0]       flush_q;
  logic [LAG_W-1:0] lag_cnt_q;
  logic             beat_q, act_in_q;
  logic [EN_W-1:0]  e0_q;

  logic [LAG_W-1:0]        out_lag_q;
  logic signed [RAW_W-1:0] out_raw_q;
  logic signed [NORM_W-1:0] out_q_q;
  logic                    out_last_q;

  logic signed [SAMPLE_BITS-1:0] ring_q [RING_DEPTH];
  logic signed [SAMPLE_BITS-1:0] y_q;

  logic [31:0] lags_c, win_t, win_c, hop_c, need_c, dist_c, rd_pos;
  logic [IDX_W-1:0] cur, nfs_eff;
  logic [KW-1:0]    last_k;
  logic             go, in_ready, in_acc, rd_en, nstart, drain, out_valid, last_lag;
  cell_ctrl_t       cctrl;

  logic signed [SAMPLE_BITS-1:0] xs [MAX_LAGS+1];
  logic                          acts [MAX_LAGS+1];
  logic signed [ACC_W-1:0]       raws [MAX_LAGS+1];
  logic [EN_W-1:0]               ens [MAX_LAGS+1];

  logic                     norm_done;
  logic signed [NORM_W-1:0] norm_q;
  logic signed [WX-1:0]     raw_x;
  logic signed [RAW_W-1:0]  raw_sat;

  // Effective framing values after clamping
  always_comb begin
    lags_c = (lags_cfg_q == '0) ? 32'd1 :
             ((32'(lags_cfg_q) > 32'(MAX_LAGS)) ? 32'(MAX_LAGS) : 32'(lags_cfg_q));
    win_t  = (win_cfg_q == '0) ? 32'd1 :
             ((32'(win_cfg_q) > 32'(MAX_WIN)) ? 32'(MAX_WIN) : 32'(win_cfg_q));
    win_c  = (win_t > 32'(RING_DEPTH) - lags_c + 32'd1) ?
             (32'(RING_DEPTH) - lags_c + 32'd1) : win_t;
    hop_c  = (hop_cfg_q == '0) ? 32'd1 : 32'(hop_cfg_q);
    need_c = win_c + lags_c - 32'd2;
  end

  // Frame decision for the sample on the input
  assign cur      = in_i.new_signal ? '0 : idx_q;
  assign nfs_eff  = in_i.new_signal ? '0 : nfs_q;
  assign dist_c   = cur - nfs_eff;
  assign go       = !dist_c[31] && (dist_c >= need_c);
  assign last_k   = KW'(need_c);
  assign rd_pos   = s_q + 32'(rd_k_q);
  assign last_lag = (32'(lag_cnt_q) == lags_c - 32'd1);

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q  <= WIN_RST;
      hop_cfg_q  <= HOP_RST;
      lags_cfg_q <= LAGS_RST;
      norm_en_q  <= NORM_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_WIN_LEN:   win_cfg_q  <= cfg_data_i[WIN_CFG_W-1:0];
        REG_HOP_LEN:   hop_cfg_q  <= cfg_data_i[HOP_CFG_W-1:0];
        REG_LAG_COUNT: lags_cfg_q <= cfg_data_i[LAGS_CFG_W-1:0];
        REG_NORMALIZE: norm_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sample ring
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ring_q[cur[RA_W-1:0]] <= in_i.sample;
    end
    if (rd_en) begin
      y_q <= ring_q[rd_pos[RA_W-1:0]];
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    nstart    = 1'b0;
    drain     = 1'b0;
    out_valid = 1'b0;
    case (state_q)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid && go) begin
          state_d = C_STREAM;
        end
      end
      C_STREAM: begin
        rd_en = 1'b1;
        if (rd_k_q == last_k) begin
          state_d = C_FLUSH;
        end
      end
      C_FLUSH: begin
        if (flush_q == 2'd3) begin
          state_d = C_NSTART;
        end
      end
      C_NSTART: begin
        nstart  = 1'b1;
        state_d = C_NWAIT;
      end
      C_NWAIT: begin
        if (norm_done) begin
          drain   = 1'b1;
          state_d = C_OUT;
        end
      end
      C_OUT: begin
        out_valid = 1'b1;
        if (out_o.ready) begin
          state_d = out_last_q ? C_IDLE : C_NSTART;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  assign in_acc      = in_i.valid & in_ready;
  assign cctrl.clear = in_acc & go;
  assign cctrl.beat  = beat_q;
  assign cctrl.drain = drain;

  // Indices, counters and stream strobes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      nfs_q     <= '0;
      s_q       <= '0;
      rd_k_q    <= '0;
      flush_q   <= '0;
      lag_cnt_q <= '0;
      beat_q    <= 1'b0;
      act_in_q  <= 1'b0;
    end else begin
      beat_q   <= rd_en;
      act_in_q <= rd_en && (32'(rd_k_q) < win_c);
      if (in_acc) begin
        idx_q   <= cur + 32'd1;
        nfs_q   <= go ? (nfs_eff + hop_c) : nfs_eff;
        rd_k_q  <= '0;
        flush_q <= '0;
        if (go) begin
          s_q <= nfs_eff;
        end
      end
      if (state_q == C_STREAM) begin
        rd_k_q <= rd_k_q + KW'(1);
      end
      if (state_q == C_FLUSH) begin
        flush_q <= flush_q + 2'd1;
        if (flush_q == 2'd3) begin
          lag_cnt_q <= '0;
        end
      end
      if (state_q == C_OUT && out_o.ready && !out_last_q) begin
        lag_cnt_q <= lag_cnt_q + LAG_W'(1);
      end
    end
  end

  // Frame energy and the output register
  always_ff @(posedge clk_i) begin
    if (state_q == C_FLUSH && flush_q == 2'd3) begin
      e0_q <= ens[0];
    end
    if (state_q == C_NWAIT && norm_done) begin
      out_lag_q  <= lag_cnt_q;
      out_raw_q  <= raw_sat;
      out_q_q    <= norm_q;
      out_last_q <= last_lag;
    end
  end

  // Saturate the head sum to the result width
  always_comb begin
    raw_x = WX'(raws[0]);
    if (raw_x > RAW_HI) begin
      raw_sat = RAW_HI[RAW_W-1:0];
    end else if (raw_x < RAW_LO) begin
      raw_sat = RAW_LO[RAW_W-1:0];
    end else begin
      raw_sat = raw_x[RAW_W-1:0];
    end
  end

  // Cell chain: taps move right each beat, sums move left on drain
  assign xs[0]          = y_q;
  assign acts[0]        = act_in_q;
  assign raws[MAX_LAGS] = '0;
  assign ens[MAX_LAGS]  = '0;

  for (genvar g = 0; g < MAX_LAGS; g++) begin : g_cell
    fnac_cell #(
      .SampleBits(SAMPLE_BITS),
      .AccW      (ACC_W),
      .EnW       (EN_W)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(cctrl),
      .y_i   (y_q),
      .x_i   (xs[g]),
      .act_i (acts[g]),
      .x_o   (xs[g+1]),
      .act_o (acts[g+1]),
      .raw_i (raws[g+1]),
      .en_i  (ens[g+1]),
      .raw_o (raws[g]),
      .en_o  (ens[g])
    );
  end

  fnac_norm #(
    .AccW(ACC_W),
    .EnW (EN_W)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(nstart),
    .en_i   (norm_en_q && (lag_cnt_q != '0)),
    .raw_i  (raws[0]),
    .e0_i   (e0_q),
    .el_i   (ens[0]),
    .done_o (norm_done),
    .q_o    (norm_q)
  );

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid;
  assign out_o.lag           = out_lag_q;
  assign out_o.raw_sum       = out_raw_q;
  assign out_o.norm_corr     = out_q_q;
  assign out_o.last_of_frame = out_last_q;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import fnac_pkg::*;

  localparam int RING_N = DEF_RING_DEPTH;

  // One result beat as the block presents it
  typedef struct packed {
    logic [LAG_W-1:0]         lag;
    logic signed [RAW_W-1:0]  raw_sum;
    logic signed [NORM_W-1:0] norm_corr;
    logic                     last_of_frame;
  } lag_result_t;

  // Predicts the lag sums of each frame and holds them until they come out
  class acorr_scoreboard;
    logic [WIN_CFG_W-1:0]  win_reg;
    logic [HOP_CFG_W-1:0]  hop_reg;
    logic [LAGS_CFG_W-1:0] lags_reg;
    logic                  norm_reg;
    logic signed [15:0]    ring [RING_N];
    bit [31:0]             sample_idx;
    bit [31:0]             frame_start;
    lag_result_t           lag_q[$];
    int unsigned           errors;

    function new();
      win_reg     = WIN_RST;
      hop_reg     = HOP_RST;
      lags_reg    = LAGS_RST;
      norm_reg    = NORM_RST;
      sample_idx  = 0;
      frame_start = 0;
      errors      = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function void set_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_WIN_LEN:   win_reg = v[WIN_CFG_W-1:0];
        REG_HOP_LEN:   hop_reg = v[HOP_CFG_W-1:0];
        REG_LAG_COUNT: lags_reg = v[LAGS_CFG_W-1:0];
        REG_NORMALIZE: norm_reg = v[0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] at(bit [31:0] pos);
      return ring[pos[10:0]];
    endfunction

    // Smallest even right shift that brings an energy below 2^32
    function int unsigned even_shift(longint unsigned e);
      int unsigned s;
      s = 0;
      while ((e >> s) >= 64'h1_0000_0000) s += 2;
      return s;
    endfunction

    // Cosine-normalized correlation in Q1.15 by exact integer root search
    function logic signed [15:0] cosine_q15(longint raw, longint unsigned e0,
                                            longint unsigned el);
      int unsigned     a, b, lo, hi, mid;
      longint unsigned p, m;
      logic [127:0]    rhs, lhs;
      if (e0 == 0 || el == 0 || raw == 0) return '0;
      a = even_shift(e0);
      b = even_shift(el);
      p = (e0 >> a) * (el >> b);
      m = (raw < 0) ? longint'(-raw) : longint'(raw);
      m = m >> ((a + b) / 2);
      if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
      rhs = 128'(m * m) << 30;
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        lhs = 128'(64'(mid) * 64'(mid)) * 128'(p);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      if (raw < 0) return 16'(-int'(lo));
      return (lo > 32767) ? 16'sd32767 : 16'(lo);
    endfunction

    // Store one accepted sample; queue the lags of a frame that is now complete
    function void take_sample(logic signed [15:0] x, logic restart);
      int unsigned     lags, win, hop;
      bit [31:0]       cur, span, st;
      longint          raw, x0, xl;
      longint unsigned e0, el;
      lag_result_t     r;
      lags = (lags_reg == 0) ? 1 : ((lags_reg > DEF_MAX_LAGS) ? DEF_MAX_LAGS : lags_reg);
      win  = (win_reg == 0) ? 1 : ((win_reg > DEF_MAX_WIN) ? DEF_MAX_WIN : win_reg);
      hop  = (hop_reg == 0) ? 1 : hop_reg;
      if (win > RING_N - lags + 1) win = RING_N - lags + 1;
      if (restart) begin
        sample_idx  = 0;
        frame_start = 0;
      end
      cur = sample_idx;
      ring[cur[10:0]] = x;
      sample_idx = cur + 1;
      span = cur - frame_start;
      if (span[31] || span < 32'(win + lags - 2)) return;
      st = frame_start;
      frame_start = st + hop;
      e0 = 0;
      for (int unsigned n = 0; n < win; n++) begin
        x0 = at(st + n);
        e0 += x0 * x0;
      end
      for (int unsigned lg = 0; lg < lags; lg++) begin
        raw = 0;
        el  = 0;
        for (int unsigned n = 0; n < win; n++) begin
          x0 = at(st + n);
          xl = at(st + n + lg);
          raw += x0 * xl;
          el  += xl * xl;
        end
        r.lag           = lg[LAG_W-1:0];
        r.norm_corr     = (norm_reg && lg > 0) ? cosine_q15(raw, e0, el) : '0;
        if (raw > 64'sh7FFF_FFFF_FFFF) raw = 64'sh7FFF_FFFF_FFFF;
        if (raw < -64'sh8000_0000_0000) raw = -64'sh8000_0000_0000;
        r.raw_sum       = raw[RAW_W-1:0];
        r.last_of_frame = (lg == lags - 1);
        lag_q.push_back(r);
      end
    endfunction

    function void check_beat(lag_result_t got);
      lag_result_t want;
      if (lag_q.size() == 0) begin
        $error("unexpected beat: lag %0d raw_sum %0d", got.lag, got.raw_sum);
        errors++;
        return;
      end
      want = lag_q.pop_front();
      if (got.lag !== want.lag) begin
        $error("lag: expected %0d, got %0d", want.lag, got.lag);
        errors++;
      end
      if (got.raw_sum !== want.raw_sum) begin
        $error("raw_sum: expected %0d, got %0d", want.raw_sum, got.raw_sum);
        errors++;
      end
      if (got.norm_corr !== want.norm_corr) begin
        $error("norm_corr: expected %0d, got %0d", want.norm_corr, got.norm_corr);
        errors++;
      end
      if (got.last_of_frame !== want.last_of_frame) begin
        $error("last_of_frame: expected %0d, got %0d", want.last_of_frame,
               got.last_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  fnac_in_if  in_bus ();
  fnac_out_if out_bus ();

  framed_normalized_autocorrelation u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  acorr_scoreboard sb = new();

  bit tx_calm;
  bit rx_calm;
  bit held_once;
  int stall_left;

  always #1 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 511)) - 16'sd256;
      2: case ($urandom_range(0, 3))
           0: return 16'sh8000;
           1: return 16'sh7FFF;
           2: return 16'sh0000;
           default: return 16'shFFFF;
         endcase
      default: return 16'($urandom_range(0, 8191)) - 16'sd4096;
    endcase
  endfunction

  // Write all four registers on consecutive edges
  task automatic program_regs(logic [10:0] w, logic [10:0] h, logic [10:0] l,
                              logic [10:0] n);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_WIN_LEN;
    cfg_data <= w;
    @(posedge clk_i);
    sb.set_reg(REG_WIN_LEN, w);
    cfg_idx  <= REG_HOP_LEN;
    cfg_data <= h;
    @(posedge clk_i);
    sb.set_reg(REG_HOP_LEN, h);
    cfg_idx  <= REG_LAG_COUNT;
    cfg_data <= l;
    @(posedge clk_i);
    sb.set_reg(REG_LAG_COUNT, l);
    cfg_idx  <= REG_NORMALIZE;
    cfg_data <= n;
    @(posedge clk_i);
    sb.set_reg(REG_NORMALIZE, n);
    cfg_we   <= 1'b0;
  endtask

  // Offer one sample beat; valid only drops when a gap follows
  task automatic send_sample(logic signed [15:0] x, logic restart);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.sample     <= x;
    in_bus.new_signal <= restart;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.take_sample(x, restart);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.lag_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [10:0] w, logic [10:0] h, logic [10:0] l,
                           logic [10:0] n, int count, bit restart, bit calm);
    program_regs(w, h, l, n);
    tx_calm = calm;
    rx_calm = calm;
    for (int i = 0; i < count; i++)
      send_sample(rand_sample(), (i == 0 && restart) || $urandom_range(0, 199) == 0);
    drain();
  endtask

  // Result side: check each beat, then choose ready for the next edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        sb.check_beat('{out_bus.lag, out_bus.raw_sum, out_bus.norm_corr,
                        out_bus.last_of_frame});
      if (!held_once && sb.lag_q.size() >= 32) begin
        held_once = 1'b1;
        stall_left = 3000;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(rx_calm);
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_WIN_LEN;
    cfg_data          = '0;
    in_bus.valid      = 1'b0;
    in_bus.sample     = '0;
    in_bus.new_signal = 1'b0;
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Single-sample window: each beat yields its own energy
    program_regs(11'd1, 11'd1, 11'd1, 11'd1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    drain();

    // Short window: full-scale, most negative, alternating and silent frames
    program_regs(11'd4, 11'd2, 11'd4, 11'd1);
    for (int i = 0; i < 4; i++) send_sample(16'sh7FFF, i == 0);
    for (int i = 0; i < 4; i++) send_sample(16'sh8000, 1'b0);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7FFF, 1'b0);
    for (int i = 0; i < 8; i++) send_sample(16'sh0000, 1'b0);
    drain();

    run_phase(11'd3, 11'd1, 11'd64, 11'd1, 70, 1'b1, 1'b0);
    run_phase(11'd16, 11'd5, 11'd8, 11'd0, 30, 1'b1, 1'b1);
    // Zero writes fall back to one
    run_phase(11'd0, 11'd0, 11'd0, 11'd1, 20, 1'b1, 1'b0);
    // Oversized lag count, framing carried over from the last phase
    run_phase(11'd9, 11'd3, 11'd127, 11'd1, 15, 1'b0, 1'b0);
    run_phase(11'd40, 11'd13, 11'd33, 11'd1, 85, 1'b1, 1'b0);
    run_phase(11'd30, 11'd7, 11'd64, 11'd1, 100, 1'b1, 1'b0);
    // Shrunk window and short hop without restart: frames already due come out one per beat
    run_phase(11'd8, 11'd2, 11'd64, 11'd0, 30, 1'b0, 1'b0);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/fnac_pkg.sv
rtl/fnac_if.sv
rtl/fnac_cell.sv
rtl/fnac_norm.sv
rtl/framed_normalized_autocorrelation.sv
test/tb.sv
